// ===== src/lsc_pkg.sv =====
package lsc_pkg;

    localparam int CHANNELS    = 6;
    localparam int SAMPLE_BITS = 12;
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int CAL_W       = 36;
    localparam int CAL_PER_REG = 3;
    localparam int SEQ_W       = 16;
    localparam int FAULT_W     = 8;
    localparam int IDX_W       = 3;

    // Q1.12 normalized sample and derived widths
    localparam int FRAC_W  = 12;
    localparam int N_W     = FRAC_W + 1;
    localparam int SUM_W   = 15;
    localparam int WSUM_W  = 17;
    localparam int POS_W   = 14;
    localparam int ERR_W   = 15;
    localparam int CONF_W  = 13;

    // shared divider
    localparam int Q_W    = 13;
    localparam int REM_W  = 18;
    localparam int DVS_W  = 17;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(FRAC_W);
    localparam logic [STEP_W-1:0] WIDE_STEPS = STEP_W'(Q_W);

    localparam logic [N_W-1:0] ONE_Q12 = N_W'(4096);
    localparam logic signed [ERR_W:0] ERR_MAX = (ERR_W+1)'(8192);
    localparam logic signed [ERR_W:0] ERR_MIN = -(ERR_W+1)'(8192);

    // register indexes
    localparam logic [IDX_W-1:0] REG_WHITE_LO = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_WHITE_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_BLACK_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_BLACK_HI = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_MIN_SUM  = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_OFFSET   = IDX_W'(5);

    localparam logic [CAL_W-1:0] RST_WHITE_LO = 36'd30708508545;
    localparam logic [CAL_W-1:0] RST_WHITE_HI = 36'd26968565316;
    localparam logic [CAL_W-1:0] RST_BLACK_LO = 36'd54403193822;
    localparam logic [CAL_W-1:0] RST_BLACK_HI = 36'd39203453280;
    localparam logic [SUM_W-1:0] RST_MIN_SUM  = SUM_W'(4096);

    typedef struct packed {
        logic [CAL_W-1:0]        white_lo;
        logic [CAL_W-1:0]        white_hi;
        logic [CAL_W-1:0]        black_lo;
        logic [CAL_W-1:0]        black_hi;
        logic [SUM_W-1:0]        min_sum;
        logic signed [POS_W-1:0] offset;
    } t_cfg;

    typedef struct packed {
        logic                                    ok;
        logic [FAULT_W-1:0]                      faults;
        logic [SEQ_W-1:0]                        seq;
        logic [CHANNELS-1:0][SAMPLE_BITS-1:0]    raw;
    } t_item;

    typedef struct packed {
        logic                     fresh;
        logic                     pulse;
        logic                     lost;
        logic                     valid;
        logic [SUM_W-1:0]         total;
        logic [CONF_W-1:0]        conf;
        logic signed [ERR_W-1:0]  err;
        logic signed [POS_W-1:0]  pos;
    } t_result;

    typedef struct packed {
        logic               start;
        logic [REM_W-1:0]   rem;
        logic [Q_W-1:0]     low;
        logic [DVS_W-1:0]   divisor;
        logic [STEP_W-1:0]  steps;
    } t_div_req;

    function automatic logic [SAMPLE_BITS-1:0] cal_field(
        input logic [CAL_W-1:0] lo,
        input logic [CAL_W-1:0] hi,
        input logic [CH_W-1:0]  ch
    );
        logic [CAL_W-1:0] r;
        logic [SAMPLE_BITS-1:0] f;
        r = (ch < CH_W'(CAL_PER_REG)) ? lo : hi;
        unique case (ch)
            CH_W'(0), CH_W'(3): f = r[SAMPLE_BITS-1:0];
            CH_W'(1), CH_W'(4): f = r[2*SAMPLE_BITS-1:SAMPLE_BITS];
            default:            f = r[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        endcase
        return f;
    endfunction

    // channel weight, centred on zero and scaled by 2
    function automatic logic signed [4:0] chan_weight(input logic [CH_W-1:0] ch);
        return 5'(2 * int'(ch) - (CHANNELS - 1));
    endfunction

endpackage

// ===== src/lsc_div.sv =====
module lsc_div
    import lsc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_div_req        i_req,
    output logic            o_done,
    output logic [Q_W-1:0]  o_quot
);

    logic [REM_W-1:0]   r_rem;
    logic [Q_W-1:0]     r_low;
    logic [Q_W-1:0]     r_quot;
    logic [DVS_W-1:0]   r_divisor;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [REM_W-1:0]   n_trial;
    logic               n_fits;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        n_trial = {r_rem[REM_W-2:0], r_low[Q_W-1]};
        n_fits  = n_trial >= REM_W'(r_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy    <= 1'b1;
                r_cnt     <= i_req.steps;
                r_rem     <= i_req.rem;
                r_low     <= i_req.low;
                r_divisor <= i_req.divisor;
                r_quot    <= '0;
            end else if (r_busy) begin
                r_rem  <= n_fits ? n_trial - REM_W'(r_divisor) : n_trial;
                r_low  <= {r_low[Q_W-2:0], 1'b0};
                r_quot <= {r_quot[Q_W-2:0], n_fits};
                r_cnt  <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== src/lsc_core.sv =====
module lsc_core
    import lsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_item_valid,
    output logic     o_item_ready,
    input  t_item    i_item,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_result  o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_CH, S_NDIV, S_ACC, S_CONF, S_CDIV, S_PDIV, S_FIN
    } t_state;

    t_state r_state;
    logic   r_out;

    t_item                    r_item;
    logic [SEQ_W-1:0]         r_seen_seq;
    logic [FAULT_W-1:0]       r_seen_faults;
    logic                     r_need;
    logic signed [POS_W-1:0]  r_held_pos;
    logic signed [ERR_W-1:0]  r_held_err;
    logic [SUM_W-1:0]         r_held_sum;
    logic [CONF_W-1:0]        r_held_conf;
    logic                     r_held_valid;
    logic                     r_held_lost;
    logic                     r_pulse;
    logic                     r_fresh;

    logic [CH_W-1:0]          r_ch;
    logic [N_W-1:0]           r_n;
    logic [SUM_W-1:0]         r_sum;
    logic signed [WSUM_W-1:0] r_wsum;
    logic signed [POS_W-1:0]  r_pos;
    t_div_req                 r_div_req;

    logic                     div_done;
    logic [Q_W-1:0]           div_quot;

    logic [SAMPLE_BITS-1:0]   n_v;
    logic [SAMPLE_BITS-1:0]   n_w;
    logic [SAMPLE_BITS-1:0]   n_b;
    logic signed [WSUM_W-1:0] n_prod;
    logic [WSUM_W-1:0]        n_wabs;
    logic signed [ERR_W:0]    n_diff;
    logic signed [ERR_W-1:0]  n_err;
    logic                     n_lost;

    lsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_v    = r_item.raw[r_ch];
        n_w    = cal_field(i_cfg.white_lo, i_cfg.white_hi, r_ch);
        n_b    = cal_field(i_cfg.black_lo, i_cfg.black_hi, r_ch);
        n_prod = $signed({{(WSUM_W-N_W){1'b0}}, r_n}) * WSUM_W'(chan_weight(r_ch));
        n_wabs = r_wsum[WSUM_W-1] ? WSUM_W'(-r_wsum) : WSUM_W'(r_wsum);
        n_lost = !r_item.ok || (r_sum < i_cfg.min_sum);
        n_diff = (ERR_W+1)'(r_pos) - (ERR_W+1)'(i_cfg.offset);
        if (n_diff > ERR_MAX) begin
            n_err = ERR_W'(ERR_MAX);
        end else if (n_diff < ERR_MIN) begin
            n_err = ERR_W'(ERR_MIN);
        end else begin
            n_err = ERR_W'(n_diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out          <= 1'b0;
            r_seen_seq     <= '0;
            r_seen_faults  <= '0;
            r_need         <= 1'b1;
            r_held_pos     <= '0;
            r_held_err     <= '0;
            r_held_sum     <= '0;
            r_held_conf    <= '0;
            r_held_valid   <= 1'b0;
            r_held_lost    <= 1'b1;
            r_pulse        <= 1'b0;
            r_fresh        <= 1'b0;
            r_div_req      <= '0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_out) begin
                if (i_res_ready) begin
                    r_out <= 1'b0;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_item_valid) begin
                            r_item  <= i_item;
                            r_pulse <= 1'b0;
                            r_fresh <= 1'b0;
                            if (i_item.faults != r_seen_faults) begin
                                r_seen_faults <= i_item.faults;
                                r_held_pos    <= '0;
                                r_held_err    <= '0;
                                r_held_sum    <= '0;
                                r_held_conf   <= '0;
                                r_held_valid  <= 1'b0;
                                r_held_lost   <= 1'b1;
                                r_need        <= 1'b1;
                            end
                            if (i_item.seq != r_seen_seq) begin
                                r_seen_seq <= i_item.seq;
                                r_fresh    <= 1'b1;
                                r_ch       <= '0;
                                r_sum      <= '0;
                                r_wsum     <= '0;
                                r_state    <= S_CH;
                            end else begin
                                r_out <= 1'b1;
                            end
                        end
                    end
                    S_CH: begin
                        if (n_v <= n_w) begin
                            r_n     <= '0;
                            r_state <= S_ACC;
                        end else if (n_v >= n_b) begin
                            r_n     <= ONE_Q12;
                            r_state <= S_ACC;
                        end else begin
                            r_div_req.start   <= 1'b1;
                            r_div_req.rem     <= REM_W'(n_v - n_w);
                            r_div_req.low     <= '0;
                            r_div_req.divisor <= DVS_W'(n_b - n_w);
                            r_div_req.steps   <= NORM_STEPS;
                            r_state           <= S_NDIV;
                        end
                    end
                    S_NDIV: begin
                        if (div_done) begin
                            r_n     <= div_quot;
                            r_state <= S_ACC;
                        end
                    end
                    S_ACC: begin
                        r_sum  <= r_sum + SUM_W'(r_n);
                        r_wsum <= r_wsum + n_prod;
                        if (r_ch == CH_W'(CHANNELS - 1)) begin
                            r_state <= S_CONF;
                        end else begin
                            r_ch    <= r_ch + CH_W'(1);
                            r_state <= S_CH;
                        end
                    end
                    S_CONF: begin
                        // sum / CHANNELS on the shared divider
                        r_div_req.start   <= 1'b1;
                        r_div_req.rem     <= REM_W'(r_sum >> Q_W);
                        r_div_req.low     <= r_sum[Q_W-1:0];
                        r_div_req.divisor <= DVS_W'(CHANNELS);
                        r_div_req.steps   <= WIDE_STEPS;
                        r_state           <= S_CDIV;
                    end
                    S_CDIV: begin
                        if (div_done) begin
                            r_held_conf  <= div_quot;
                            r_held_sum   <= r_sum;
                            r_held_valid <= r_item.ok;
                            r_held_lost  <= n_lost;
                            r_pos        <= '0;
                            if (n_lost) begin
                                r_held_pos <= '0;
                                r_held_err <= '0;
                                r_need     <= 1'b1;
                                r_state    <= S_IDLE;
                                r_out      <= 1'b1;
                            end else if (r_sum == '0) begin
                                r_state <= S_FIN;
                            end else begin
                                // |wsum| * 4096 / ((CHANNELS-1) * sum)
                                r_div_req.start   <= 1'b1;
                                r_div_req.rem     <= REM_W'(n_wabs >> 1);
                                r_div_req.low     <= {n_wabs[0], {(Q_W-1){1'b0}}};
                                r_div_req.divisor <= DVS_W'({r_sum, 2'b00}) + DVS_W'(r_sum);
                                r_div_req.steps   <= WIDE_STEPS;
                                r_state           <= S_PDIV;
                            end
                        end
                    end
                    S_PDIV: begin
                        if (div_done) begin
                            r_pos   <= r_wsum[WSUM_W-1] ? -POS_W'(div_quot)
                                                        : POS_W'(div_quot);
                            r_state <= S_FIN;
                        end
                    end
                    S_FIN: begin
                        r_held_pos <= r_pos;
                        r_held_err <= n_err;
                        if (r_need) begin
                            r_pulse <= 1'b1;
                            r_need  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                        r_out   <= 1'b1;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_item_ready = (r_state == S_IDLE) && !r_out;
    assign o_res_valid  = r_out;

    always_comb begin
        o_res.fresh = r_fresh;
        o_res.pulse = r_pulse;
        o_res.lost  = r_held_lost;
        o_res.valid = r_held_valid;
        o_res.total = r_held_sum;
        o_res.conf  = r_held_conf;
        o_res.err   = r_held_err;
        o_res.pos   = r_held_pos;
    end

endmodule

// ===== src/line_sensor_centroid_top.sv =====
// channel      dir   handshake                      payload
// snapshot in  in    s_axis_tvalid / s_axis_tready  s_axis_tdata, s_axis_tuser
// status out   out   m_axis_tvalid / m_axis_tready  m_axis_tdata, m_axis_tuser
// config       in    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one item at a time; a repeated sequence number is answered from the held
// result, a new one is worked through on the bit-serial divider (one quotient
// bit a cycle, up to six normalizations, confidence and centroid)
// reset is synchronous; config returns to the calibration defaults
// the result waits in an output register, so a stalled output holds off
// only the next result, not the next item's capture
module line_sensor_centroid_top
    import lsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // raw_ch0 .. raw_ch5, snapshot_seq, fault_count
    input  logic [95:0]      s_axis_tdata,
    // snapshot_ok
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // line_position, centered_err, confidence, signal_total, zero pad
    output logic [63:0]      m_axis_tdata,
    // status_valid, line_lost, reacquire_pulse, fresh
    output logic [3:0]       m_axis_tuser,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CAL_W-1:0] i_cfg_data
);

    t_cfg        r_cfg;
    t_item       item;
    t_result     res;
    logic        res_valid;
    logic        res_ready;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [3:0]  r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.white_lo <= RST_WHITE_LO;
            r_cfg.white_hi <= RST_WHITE_HI;
            r_cfg.black_lo <= RST_BLACK_LO;
            r_cfg.black_hi <= RST_BLACK_HI;
            r_cfg.min_sum  <= RST_MIN_SUM;
            r_cfg.offset   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WHITE_LO: r_cfg.white_lo <= i_cfg_data;
                REG_WHITE_HI: r_cfg.white_hi <= i_cfg_data;
                REG_BLACK_LO: r_cfg.black_lo <= i_cfg_data;
                REG_BLACK_HI: r_cfg.black_hi <= i_cfg_data;
                REG_MIN_SUM:  r_cfg.min_sum  <= i_cfg_data[SUM_W-1:0];
                REG_OFFSET:   r_cfg.offset   <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        item.ok     = s_axis_tuser[0];
        item.faults = s_axis_tdata[95:88];
        item.seq    = s_axis_tdata[87:72];
        item.raw    = s_axis_tdata[71:0];
    end

    lsc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {7'b0, res.total, res.conf, res.err, res.pos};
                r_out_user  <= {res.fresh, res.pulse, res.lost, res.valid};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
